### hw/rtl/sctp_header_crc32c_check_top_defines.svh
// assertion macros for the sctp checksum checker
`ifndef SCTP_HEADER_CRC32C_CHECK_TOP_DEFINES_SVH
`define SCTP_HEADER_CRC32C_CHECK_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SCTPCRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define SCTPCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sctpcrc_pkg.sv
// shared types, constants and the crc-32c byte update for the sctp checksum checker
package sctpcrc_pkg;

    // header layout, in bytes from the start of the packet
    localparam logic [3:0] HEADER_BYTES = 4'd12;
    localparam logic [3:0] SRC_END      = 4'd2;
    localparam logic [3:0] DST_END      = 4'd4;
    localparam logic [3:0] SUM_FIRST    = 4'd8;
    localparam logic [3:0] SUM_END      = 4'd12;

    // reflected crc-32c
    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SHORT   = 2'd1,
        STATUS_BAD_SUM = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] received_sum;
        logic [31:0] computed_sum;
        logic [31:0] packet_total;
        logic [31:0] byte_total;
        logic [31:0] short_total;
        logic [31:0] bad_sum_total;
    } out_item_t;

    // output register status seen by the pipeline control
    typedef struct packed {
        logic full;
        logic draining;
    } out_ctrl_t;

    // one byte through the reflected crc, lsb first
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

### hw/rtl/sctpcrc_in_stage.sv
// input register stage: holds one accepted byte until the core takes it
module sctpcrc_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  sctpcrc_pkg::in_item_t item,
    input  logic                  advance,
    output logic                  stage_valid,
    output sctpcrc_pkg::in_item_t stage_item
);
    import sctpcrc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // room when empty or when the held byte moves on this cycle
    assign item_ready = !valid_reg || advance;
    assign valid_next = item_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

### hw/rtl/sctpcrc_core.sv
// packet state, crc update, header capture and running totals
module sctpcrc_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  sctpcrc_pkg::in_item_t  stage_item,
    output sctpcrc_pkg::out_item_t result
);
    import sctpcrc_pkg::*;

    logic [31:0] crc_reg,       crc_next;
    logic [3:0]  header_pos_reg, header_pos_next;
    logic [15:0] src_port_reg,  src_port_next;
    logic [15:0] dst_port_reg,  dst_port_next;
    logic [31:0] sum_field_reg, sum_field_next;
    logic [31:0] packet_count_reg,  packet_count_next;
    logic [31:0] byte_count_reg,    byte_count_next;
    logic [31:0] short_count_reg,   short_count_next;
    logic [31:0] bad_sum_count_reg, bad_sum_count_next;

    logic [7:0]  b;
    logic [7:0]  feed;
    logic        in_sum;
    logic        is_short;
    logic        is_bad;
    logic [31:0] cs;

    // header capture and crc for this byte
    always_comb
    begin
        b      = stage_item.data_byte;
        in_sum = (header_pos_reg >= SUM_FIRST) && (header_pos_reg < SUM_END);
        feed   = in_sum ? 8'd0 : b;

        src_port_next  = src_port_reg;
        dst_port_next  = dst_port_reg;
        sum_field_next = sum_field_reg;
        if (header_pos_reg < SRC_END)
        begin
            src_port_next = {src_port_reg[7:0], b};
        end
        else if (header_pos_reg < DST_END)
        begin
            dst_port_next = {dst_port_reg[7:0], b};
        end
        else if (in_sum)
        begin
            sum_field_next = {sum_field_reg[23:0], b};
        end

        crc_next        = crc32c_byte(crc_reg, feed);
        header_pos_next = (header_pos_reg < HEADER_BYTES) ? header_pos_reg + 4'd1
                                                          : header_pos_reg;
    end

    // end-of-packet verdict and totals
    always_comb
    begin
        cs       = swap32(~crc_next);
        is_short = header_pos_next < HEADER_BYTES;
        is_bad   = !is_short && (cs != sum_field_next);

        byte_count_next    = byte_count_reg + 32'd1;
        packet_count_next  = packet_count_reg + {31'd0, stage_item.last_byte};
        short_count_next   = short_count_reg + {31'd0, stage_item.last_byte && is_short};
        bad_sum_count_next = bad_sum_count_reg + {31'd0, stage_item.last_byte && is_bad};

        result.status        = is_short ? STATUS_SHORT : (is_bad ? STATUS_BAD_SUM : STATUS_OK);
        result.source_port   = is_short ? 16'd0 : src_port_next;
        result.dest_port     = is_short ? 16'd0 : dst_port_next;
        result.received_sum  = is_short ? 32'd0 : sum_field_next;
        result.computed_sum  = is_short ? 32'd0 : cs;
        result.packet_total  = packet_count_next;
        result.byte_total    = byte_count_next;
        result.short_total   = short_count_next;
        result.bad_sum_total = bad_sum_count_next;
    end

    // state update, packet state restarts after a final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg           <= CRC_INIT;
            header_pos_reg    <= 4'd0;
            src_port_reg      <= 16'd0;
            dst_port_reg      <= 16'd0;
            sum_field_reg     <= 32'd0;
            packet_count_reg  <= 32'd0;
            byte_count_reg    <= 32'd0;
            short_count_reg   <= 32'd0;
            bad_sum_count_reg <= 32'd0;
        end
        else if (take)
        begin
            packet_count_reg  <= packet_count_next;
            byte_count_reg    <= byte_count_next;
            short_count_reg   <= short_count_next;
            bad_sum_count_reg <= bad_sum_count_next;
            if (stage_item.last_byte)
            begin
                crc_reg        <= CRC_INIT;
                header_pos_reg <= 4'd0;
                src_port_reg   <= 16'd0;
                dst_port_reg   <= 16'd0;
                sum_field_reg  <= 32'd0;
            end
            else
            begin
                crc_reg        <= crc_next;
                header_pos_reg <= header_pos_next;
                src_port_reg   <= src_port_next;
                dst_port_reg   <= dst_port_next;
                sum_field_reg  <= sum_field_next;
            end
        end
    end

endmodule

### hw/rtl/sctpcrc_out_stage.sv
// result register: holds one packet verdict until the consumer takes it
module sctpcrc_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  sctpcrc_pkg::out_item_t load_item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output sctpcrc_pkg::out_item_t result,
    output sctpcrc_pkg::out_ctrl_t ctrl
);
    import sctpcrc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t result_reg;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_item;
        end
    end

    assign result_valid  = valid_reg;
    assign result        = result_reg;
    assign ctrl.full     = valid_reg;
    assign ctrl.draining = valid_reg && result_ready;

endmodule

### hw/rtl/sctp_header_crc32c_check_top.sv
// top level of the sctp header and crc-32c checksum checker
//
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_ready     item   (data_byte, last_byte)
//  result    out        result_valid / result_ready result (status, ports, sums, totals)
//
// one byte per cycle unless a stalled result holds a final byte; a byte sits in the input
// register after its transfer, and a final byte's verdict enters the result register as
// the byte moves on. the byte-wide crc update between the input and result registers sets
// the clock rate. reset clears the crc to all ones, the header position, captures and all
// totals. a stalled result holds a final byte and those behind it; others keep flowing.
module sctp_header_crc32c_check_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  sctpcrc_pkg::in_item_t  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output sctpcrc_pkg::out_item_t result
);
    import sctpcrc_pkg::*;

`include "sctp_header_crc32c_check_top_defines.svh"

    logic      stage_valid;
    in_item_t  stage_item;
    out_item_t core_result;
    out_ctrl_t out_ctrl;
    logic      advance;
    logic      load;

    // a byte moves on unless it is final and the result register is blocked
    assign advance = stage_valid && (!stage_item.last_byte || !out_ctrl.full
                                     || out_ctrl.draining);
    assign load    = advance && stage_item.last_byte;

    sctpcrc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    sctpcrc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (advance),
        .stage_item (stage_item),
        .result     (core_result)
    );

    sctpcrc_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .load_item    (core_result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .ctrl         (out_ctrl)
    );

    // checks on the verdict and the pipeline flow
    `SCTPCRC_ASSERT_NEXT(a_final_gives_result, load, result_valid,
        "final byte gave no result")
    `SCTPCRC_ASSERT_SAME(a_short_zeroed,
        result_valid && (result.status == STATUS_SHORT),
        (result.computed_sum == 32'd0) && (result.received_sum == 32'd0),
        "short packet sums not zero")
    `SCTPCRC_ASSERT_SAME(a_ok_match,
        result_valid && (result.status == STATUS_OK),
        result.computed_sum == result.received_sum,
        "ok status with mismatched sums")
    `SCTPCRC_ASSERT_SAME(a_bad_mismatch,
        result_valid && (result.status == STATUS_BAD_SUM),
        result.computed_sum != result.received_sum,
        "bad status with matching sums")

endmodule

### tb/sctp_header_crc32c_check_top_tb.sv
`timescale 1ns / 100ps
// testbench for the sctp checksum checker: directed rows, then random packets scored by a predictor
module sctp_header_crc32c_check_top_tb;
    import sctpcrc_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 600;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    int send_idle_pct = 6;
    int recv_idle_pct = 77;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    out_item_t   verdicts_due[$];
    dir_row_t    dir_rows[$];
    logic [7:0]  pkt_bytes[$];

    // predictor copy of the checker state
    logic [31:0] crc_acc       = CRC_INIT;
    logic [3:0]  hdr_count     = '0;
    logic [15:0] src_cap       = '0;
    logic [15:0] dst_cap       = '0;
    logic [31:0] sum_cap       = '0;
    logic [31:0] packets_seen  = '0;
    logic [31:0] bytes_seen    = '0;
    logic [31:0] shorts_seen   = '0;
    logic [31:0] bad_sums_seen = '0;

    sctp_header_crc32c_check_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // reflected crc-32c, one bit per pass
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC32C_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic last, input bit typed,
                                    input out_item_t want);
        dir_row_t r;
        r.stim.data_byte = b;
        r.stim.last_byte = last;
        r.typed          = typed;
        r.want           = want;
        dir_rows.push_back(r);
    endfunction

    // predictor: advance state by one byte, queue a verdict on a final byte
    task automatic predict_byte(input in_item_t it, input bit typed, input out_item_t want);
        logic [7:0]  feed;
        logic [31:0] inv;
        out_item_t   v;
        feed = it.data_byte;
        if (hdr_count < SRC_END)
            src_cap = {src_cap[7:0], it.data_byte};
        else if (hdr_count < DST_END)
            dst_cap = {dst_cap[7:0], it.data_byte};
        else if (hdr_count >= SUM_FIRST && hdr_count < SUM_END)
        begin
            sum_cap = {sum_cap[23:0], it.data_byte};
            feed    = 8'h00;
        end
        crc_acc    = crc_step(crc_acc, feed);
        bytes_seen = bytes_seen + 32'd1;
        if (hdr_count < HEADER_BYTES)
            hdr_count = hdr_count + 4'd1;
        if (it.last_byte)
        begin
            packets_seen = packets_seen + 32'd1;
            v = '0;
            if (hdr_count < HEADER_BYTES)
            begin
                v.status    = STATUS_SHORT;
                shorts_seen = shorts_seen + 32'd1;
            end
            else
            begin
                inv            = ~crc_acc;
                v.source_port  = src_cap;
                v.dest_port    = dst_cap;
                v.received_sum = sum_cap;
                v.computed_sum = {inv[7:0], inv[15:8], inv[23:16], inv[31:24]};
                if (v.computed_sum != sum_cap)
                begin
                    v.status      = STATUS_BAD_SUM;
                    bad_sums_seen = bad_sums_seen + 32'd1;
                end
                else
                    v.status = STATUS_OK;
            end
            v.packet_total  = packets_seen;
            v.byte_total    = bytes_seen;
            v.short_total   = shorts_seen;
            v.bad_sum_total = bad_sums_seen;
            verdicts_due.push_back(typed ? want : v);
            // next packet starts clean
            crc_acc   = CRC_INIT;
            hdr_count = '0;
            src_cap   = '0;
            dst_cap   = '0;
            sum_cap   = '0;
        end
    endtask

    // one byte transfer, then maybe a sender gap
    task automatic send_byte(input in_item_t it, input bit typed, input out_item_t want);
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_byte(it, typed, want);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // random packet: mostly well formed with a correct sum, some corrupted, some short
    task automatic send_random_packet(output int len);
        int          kind;
        int          spot;
        logic [31:0] crc;
        logic [31:0] good;
        in_item_t    it;
        out_item_t   none;
        none = '0;
        kind = $urandom_range(99);
        if (kind < 15)
            len = $urandom_range(11, 1);
        else if (kind < 22)
            len = $urandom_range(80, 25);
        else
            len = $urandom_range(24, 12);
        pkt_bytes.delete();
        for (int i = 0; i < len; i++)
            pkt_bytes.push_back(8'($urandom_range(255)));
        if (len >= HEADER_BYTES)
        begin
            // fill in the checksum that makes the packet valid
            for (int i = int'(SUM_FIRST); i < int'(SUM_END); i++)
                pkt_bytes[i] = 8'h00;
            crc = CRC_INIT;
            for (int i = 0; i < len; i++)
                crc = crc_step(crc, pkt_bytes[i]);
            crc  = ~crc;
            good = {crc[7:0], crc[15:8], crc[23:16], crc[31:24]};
            pkt_bytes[8]  = good[31:24];
            pkt_bytes[9]  = good[23:16];
            pkt_bytes[10] = good[15:8];
            pkt_bytes[11] = good[7:0];
            // corrupt one bit in about a third of them
            if ($urandom_range(99) < 30)
            begin
                spot = $urandom_range(len - 1);
                pkt_bytes[spot] = pkt_bytes[spot] ^ (8'h01 << $urandom_range(7));
            end
        end
        for (int i = 0; i < len; i++)
        begin
            it.data_byte = pkt_bytes[i];
            it.last_byte = (i == len - 1);
            send_byte(it, 1'b0, none);
        end
    endtask

    task automatic compare_verdict(input out_item_t got, input out_item_t want);
        if (got.status != want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.source_port != want.source_port)
        begin
            $error("source_port: expected %h, got %h", want.source_port, got.source_port);
            fail_count++;
        end
        if (got.dest_port != want.dest_port)
        begin
            $error("dest_port: expected %h, got %h", want.dest_port, got.dest_port);
            fail_count++;
        end
        if (got.received_sum != want.received_sum)
        begin
            $error("received_sum: expected %h, got %h", want.received_sum, got.received_sum);
            fail_count++;
        end
        if (got.computed_sum != want.computed_sum)
        begin
            $error("computed_sum: expected %h, got %h", want.computed_sum, got.computed_sum);
            fail_count++;
        end
        if (got.packet_total != want.packet_total)
        begin
            $error("packet_total: expected %0d, got %0d", want.packet_total, got.packet_total);
            fail_count++;
        end
        if (got.byte_total != want.byte_total)
        begin
            $error("byte_total: expected %0d, got %0d", want.byte_total, got.byte_total);
            fail_count++;
        end
        if (got.short_total != want.short_total)
        begin
            $error("short_total: expected %0d, got %0d", want.short_total, got.short_total);
            fail_count++;
        end
        if (got.bad_sum_total != want.bad_sum_total)
        begin
            $error("bad_sum_total: expected %0d, got %0d", want.bad_sum_total,
                   got.bad_sum_total);
            fail_count++;
        end
    endtask

    // receiver back-pressure
    always @(posedge clk)
    begin
        result_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // score each result transfer against the oldest verdict
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("unexpected result transfer: status %0d", result.status);
                fail_count++;
            end
            else
                compare_verdict(result, verdicts_due.pop_front());
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial
    begin
        out_item_t w;
        int        len;
        int        phase_bytes;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // single zero byte right after reset: too short
        w = '0;
        w.status       = STATUS_SHORT;
        w.packet_total = 1;
        w.byte_total   = 1;
        w.short_total  = 1;
        add_row(8'h00, 1'b1, 1'b1, w);
        // single all-ones byte: too short
        w.packet_total = 2;
        w.byte_total   = 2;
        w.short_total  = 2;
        add_row(8'hFF, 1'b1, 1'b1, w);
        // one byte short of a full header
        for (int i = 0; i < 10; i++)
            add_row((i % 2) ? 8'h00 : 8'hFF, 1'b0, 1'b0, '0);
        w.packet_total = 3;
        w.byte_total   = 13;
        w.short_total  = 3;
        add_row(8'h00, 1'b1, 1'b1, w);
        // exactly a header, all ones
        for (int i = 0; i < 12; i++)
            add_row(8'hFF, i == 11, 1'b0, '0);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        // three idle profiles, each opened by a full drain of pending verdicts
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 77 : 0;
            recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 6 : 0;
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while (verdicts_due.size() != 0);
            phase_bytes = 0;
            while (phase_bytes < RANDOM_BYTES / 3)
            begin
                send_random_packet(len);
                phase_bytes += len;
            end
        end

        // drain and settle
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (verdicts_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
